FILE: hdl/oahq_pkg.sv
// Shared types and constants of the open-addressed hash table.
// Used by the controller, the datapath and the top level; depends on nothing.
package oahq_pkg;

  localparam int SLOTS       = 4096;
  localparam int ADDR_W      = 12;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 13;
  localparam int TAG_W       = 2;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = 4;
  localparam int DIV_W       = 7;

  localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
  localparam logic [TAG_W-1:0] TAG_OCC   = 2'd1;
  localparam logic [TAG_W-1:0] TAG_DEL   = 2'd2;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;
  localparam logic [1:0] REQ_BAD    = 2'd3;

  localparam logic [1:0] RES_DONE = 2'd0;
  localparam logic [1:0] RES_MISS = 2'd1;
  localparam logic [1:0] RES_FULL = 2'd2;

  localparam logic CFG_INIT_SIZE   = 1'b0;
  localparam logic CFG_PROBE_LIMIT = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR_STEP,
    OP_ACCEPT,
    OP_HOME_START,
    OP_HOME_SET,
    OP_PROBE_RD,
    OP_PROBE_STEP,
    OP_LK_FOUND,
    OP_LK_MISS,
    OP_PLACE_WRITE,
    OP_DROP,
    OP_CAND_GROW,
    OP_CAND_SHRINK,
    OP_CAND_INC,
    OP_CAND_DEC,
    OP_PR_INIT,
    OP_PR_DIV,
    OP_PR_NEXTD,
    OP_PUSH,
    OP_POP,
    OP_RB_START,
    OP_RB_RD,
    OP_RB_MOVE,
    OP_RB_END,
    OP_FETCH_SCR,
    OP_LOAD_SCR,
    OP_FIN_INS,
    OP_FIN_RM,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       div_done;
    logic       tag_empty;
    logic       tag_occ;
    logic       key_match;
    logic       cnt_ge_limit;
    logic       cnt_gt_size;
    logic       shrink_due;
    logic       next_lt_end;
    logic       sp_zero;
    logic       sp_full;
    logic       size_big;
    logic       dsq_gt_cand;
    logic       rem_zero;
    logic       cand_over;
    logic       cand_le2;
    logic       scan_lt_size;
    logic       clr_last;
    logic       out_free;
    logic       cfg_clear;
  } dp_stat_t;

endpackage

FILE: hdl/oahq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package needed.
module oahq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/oahq_div.sv
// Bit-serial remainder unit: one quotient bit per cycle over a 32-bit dividend.
// Depends on oahq_pkg for widths.
module oahq_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [oahq_pkg::KEY_W-1:0]    dividend,
  input  logic [oahq_pkg::CNT_W-1:0]    divisor,
  output logic                          done,
  output logic [oahq_pkg::CNT_W-1:0]    rem
);

  logic                        busy;
  logic [4:0]                  count;
  logic [oahq_pkg::KEY_W-1:0]  quo;
  logic [oahq_pkg::CNT_W-1:0]  dvsr;
  logic [oahq_pkg::CNT_W:0]    trial;
  logic [oahq_pkg::CNT_W-1:0]  rem_next;

  always_comb begin
    trial = {rem, quo[oahq_pkg::KEY_W-1]};
    if (trial >= {1'b0, dvsr}) begin
      rem_next = oahq_pkg::CNT_W'(trial - {1'b0, dvsr});
    end else begin
      rem_next = trial[oahq_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
        quo <= dividend;
        dvsr <= divisor;
        rem <= '0;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[oahq_pkg::KEY_W-2:0], 1'b0};
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/oahq_ctrl.sv
// Sequencer of the hash table: lookup, placement, growth, shrink and rebuild.
// Depends on oahq_pkg; drives the datapath by one command a cycle.
module oahq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_type,
  input  oahq_pkg::dp_stat_t stat,
  output oahq_pkg::dp_op_t  op,
  output logic              ready
);

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_HWAIT,
    ST_RD,
    ST_CHK,
    ST_FETCH,
    ST_SCR_LOAD,
    ST_GROW,
    ST_PR_INIT,
    ST_PR_TEST,
    ST_PR_WAIT,
    ST_RB_BEGIN,
    ST_RB_RD,
    ST_RB_CHK,
    ST_RM_CHK,
    ST_DONE
  } state_t;

  state_t state, state_next;
  logic   placing, placing_next;
  logic   shrinking, shrinking_next;

  assign ready = (state == ST_IDLE) && !stat.cfg_clear;

  always_comb begin
    op = oahq_pkg::OP_NONE;
    state_next = state;
    placing_next = placing;
    shrinking_next = shrinking;
    case (state)
      ST_CLEAR: begin
        if (!stat.cfg_clear) begin
          op = oahq_pkg::OP_CLR_STEP;
          if (stat.clr_last) state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (stat.cfg_clear) begin
          state_next = ST_CLEAR;
        end else if (in_valid) begin
          op = oahq_pkg::OP_ACCEPT;
          placing_next = 1'b0;
          state_next = (in_type == oahq_pkg::REQ_BAD) ? ST_DONE : ST_HOME;
        end
      end
      ST_HOME: begin
        op = oahq_pkg::OP_HOME_START;
        state_next = ST_HWAIT;
      end
      ST_HWAIT: begin
        if (stat.div_done) begin
          op = oahq_pkg::OP_HOME_SET;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        op = oahq_pkg::OP_PROBE_RD;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (placing) begin
          if (!stat.tag_occ) begin
            op = oahq_pkg::OP_PLACE_WRITE;
            state_next = ST_FETCH;
          end else if (stat.cnt_ge_limit) begin
            state_next = ST_GROW;
          end else if (stat.cnt_gt_size) begin
            op = oahq_pkg::OP_DROP;
            state_next = ST_FETCH;
          end else begin
            op = oahq_pkg::OP_PROBE_STEP;
            state_next = ST_RD;
          end
        end else if (stat.tag_occ && stat.key_match) begin
          op = oahq_pkg::OP_LK_FOUND;
          state_next = (stat.req_type == oahq_pkg::REQ_REMOVE) ? ST_RM_CHK : ST_DONE;
        end else if (stat.tag_empty || stat.cnt_gt_size) begin
          // key absent: an insert goes on to place it
          if (stat.req_type == oahq_pkg::REQ_INSERT) begin
            placing_next = 1'b1;
            state_next = ST_HOME;
          end else begin
            op = oahq_pkg::OP_LK_MISS;
            state_next = ST_DONE;
          end
        end else begin
          op = oahq_pkg::OP_PROBE_STEP;
          state_next = ST_RD;
        end
      end
      ST_GROW: begin
        if (stat.size_big || stat.sp_full) begin
          op = oahq_pkg::OP_DROP;
          state_next = ST_FETCH;
        end else begin
          op = oahq_pkg::OP_CAND_GROW;
          shrinking_next = 1'b0;
          state_next = ST_PR_INIT;
        end
      end
      ST_PR_INIT: begin
        if (shrinking && stat.cand_le2) begin
          op = oahq_pkg::OP_RB_START;
          state_next = ST_RB_RD;
        end else begin
          op = oahq_pkg::OP_PR_INIT;
          state_next = ST_PR_TEST;
        end
      end
      ST_PR_TEST: begin
        if (stat.dsq_gt_cand) begin
          if (shrinking) begin
            op = oahq_pkg::OP_RB_START;
            state_next = ST_RB_RD;
          end else if (stat.cand_over) begin
            op = oahq_pkg::OP_DROP;
            state_next = ST_FETCH;
          end else begin
            op = oahq_pkg::OP_PUSH;
            state_next = ST_RB_BEGIN;
          end
        end else begin
          op = oahq_pkg::OP_PR_DIV;
          state_next = ST_PR_WAIT;
        end
      end
      ST_PR_WAIT: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            op = shrinking ? oahq_pkg::OP_CAND_DEC : oahq_pkg::OP_CAND_INC;
            state_next = ST_PR_INIT;
          end else begin
            op = oahq_pkg::OP_PR_NEXTD;
            state_next = ST_PR_TEST;
          end
        end
      end
      ST_RB_BEGIN: begin
        op = oahq_pkg::OP_RB_START;
        state_next = ST_RB_RD;
      end
      ST_RB_RD: begin
        if (stat.scan_lt_size) begin
          op = oahq_pkg::OP_RB_RD;
          state_next = ST_RB_CHK;
        end else begin
          op = oahq_pkg::OP_RB_END;
          placing_next = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_RB_CHK: begin
        op = oahq_pkg::OP_RB_MOVE;
        state_next = ST_RB_RD;
      end
      ST_FETCH: begin
        if (stat.next_lt_end) begin
          op = oahq_pkg::OP_FETCH_SCR;
          state_next = ST_SCR_LOAD;
        end else if (!stat.sp_zero) begin
          op = oahq_pkg::OP_POP;
          state_next = ST_HOME;
        end else begin
          op = (stat.req_type == oahq_pkg::REQ_INSERT) ? oahq_pkg::OP_FIN_INS
                                                       : oahq_pkg::OP_FIN_RM;
          state_next = ST_DONE;
        end
      end
      ST_SCR_LOAD: begin
        op = oahq_pkg::OP_LOAD_SCR;
        state_next = ST_HOME;
      end
      ST_RM_CHK: begin
        if (stat.shrink_due) begin
          op = oahq_pkg::OP_CAND_SHRINK;
          shrinking_next = 1'b1;
          state_next = ST_PR_INIT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          op = oahq_pkg::OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      placing <= 1'b0;
      shrinking <= 1'b0;
    end else begin
      state <= state_next;
      placing <= placing_next;
      shrinking <= shrinking_next;
    end
  end

endmodule

FILE: hdl/oahq_dp.sv
// Datapath of the hash table: slot and scratch memories, probe arithmetic,
// counters, rebuild stack and output register. Depends on oahq_pkg,
// oahq_ram and oahq_div.
module oahq_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  oahq_pkg::dp_op_t              op,
  output oahq_pkg::dp_stat_t            stat,
  input  logic [1:0]                    in_type,
  input  logic [oahq_pkg::KEY_W-1:0]    in_key,
  input  logic [oahq_pkg::VAL_W-1:0]    in_value,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [oahq_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [oahq_pkg::ADDR_W-1:0]   out_slot,
  output logic [oahq_pkg::CNT_W-1:0]    out_probes,
  output logic [oahq_pkg::VAL_W-1:0]    out_found_value,
  output logic [oahq_pkg::CNT_W-1:0]    out_table_size,
  output logic [oahq_pkg::CNT_W-1:0]    out_entry_count,
  output logic [oahq_pkg::CNT_W-1:0]    out_longest_probe
);

  localparam int SW = oahq_pkg::CNT_W;
  localparam int AW = oahq_pkg::ADDR_W;
  localparam int KW = oahq_pkg::KEY_W;
  localparam int VW = oahq_pkg::VAL_W;
  localparam int MW = oahq_pkg::TAG_W + KW + VW;

  typedef struct packed {
    logic [KW-1:0] key;
    logic [VW-1:0] data;
    logic [SW-1:0] nxt;
    logic [SW-1:0] endp;
    logic          is_req;
  } frame_t;

  // configuration and table state
  logic [AW-1:0] init_size;
  logic [SW-1:0] probe_limit;
  logic [SW-1:0] cur_size, occ, del, max_run;
  logic [SW-1:0] min_size, cfg_min;

  // request and entry being placed
  logic [1:0]    req_type;
  logic [KW-1:0] work_key;
  logic [VW-1:0] work_data;
  logic          is_req;

  // probe walk
  logic [AW-1:0] pos, delta;
  logic [SW-1:0] cnt;

  // rebuild engine
  logic [SW-1:0]      nxt, endp, scan, copied, new_size;
  logic [oahq_pkg::SP_W-1:0] sp;
  frame_t             stack [oahq_pkg::STACK_DEPTH];
  frame_t             top_frame;
  logic [SW-1:0]      cand;
  logic [oahq_pkg::DIV_W-1:0] dvs;
  logic [AW-1:0]      clr;

  // result
  logic [1:0]    res_status;
  logic [AW-1:0] res_slot;
  logic [SW-1:0] res_probes;
  logic [VW-1:0] res_fv;
  logic          dropped, stored;
  logic [AW-1:0] stored_slot;
  logic [SW-1:0] stored_run;

  // memories
  logic          slot_we, slot_re;
  logic [AW-1:0] slot_waddr, slot_raddr;
  logic [MW-1:0] slot_wdata, slot_rdata;
  logic [oahq_pkg::TAG_W-1:0] rd_tag;
  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_data;
  logic          scr_we, scr_re;
  logic [KW+VW-1:0] scr_rdata;

  // divider
  logic          div_start, div_done;
  logic [KW-1:0] div_dividend, key_mag;
  logic [SW-1:0] div_divisor, div_rem;

  // arithmetic
  logic [SW-1:0] pos_sum, delta_sum, home;
  logic [SW-1:0] half;
  logic [SW+2:0] five_occ;
  logic [2*oahq_pkg::DIV_W-1:0] dsq;

  assign min_size = (init_size < AW'(2)) ? SW'(2) : {1'b0, init_size};
  assign cfg_min  = (cfg_data[AW-1:0] < AW'(2)) ? SW'(2) : {1'b0, cfg_data[AW-1:0]};

  assign rd_tag  = slot_rdata[MW-1 -: oahq_pkg::TAG_W];
  assign rd_key  = slot_rdata[KW+VW-1 -: KW];
  assign rd_data = slot_rdata[VW-1:0];

  assign key_mag   = work_key[KW-1] ? (~work_key + KW'(1)) : work_key;
  assign pos_sum   = {1'b0, pos} + {1'b0, delta};
  assign delta_sum = {1'b0, delta} + SW'(2);
  assign home      = (work_key[KW-1] && (div_rem != '0)) ? (cur_size - div_rem) : div_rem;
  assign half      = {1'b0, cur_size[SW-1:1]};
  assign five_occ  = {occ, 2'b00} + {2'b00, occ};
  assign dsq       = dvs * dvs;
  assign top_frame = stack[sp - oahq_pkg::SP_W'(1)];

  assign div_start    = (op == oahq_pkg::OP_HOME_START) || (op == oahq_pkg::OP_PR_DIV);
  assign div_dividend = (op == oahq_pkg::OP_HOME_START) ? key_mag : KW'(cand);
  assign div_divisor  = (op == oahq_pkg::OP_HOME_START) ? cur_size : SW'(dvs);

  oahq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  // slot memory: tag, key and data in one word
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = pos;
    slot_wdata = {oahq_pkg::TAG_EMPTY, work_key, work_data};
    slot_re    = 1'b0;
    slot_raddr = pos;
    case (op)
      oahq_pkg::OP_CLR_STEP: begin
        slot_we = 1'b1;
        slot_waddr = clr;
      end
      oahq_pkg::OP_LK_FOUND: begin
        slot_we = (req_type == oahq_pkg::REQ_REMOVE);
        slot_wdata = {oahq_pkg::TAG_DEL, work_key, work_data};
      end
      oahq_pkg::OP_PLACE_WRITE: begin
        slot_we = 1'b1;
        slot_wdata = {oahq_pkg::TAG_OCC, work_key, work_data};
      end
      oahq_pkg::OP_RB_MOVE: begin
        slot_we = 1'b1;
        slot_waddr = scan[AW-1:0];
      end
      oahq_pkg::OP_PROBE_RD: begin
        slot_re = 1'b1;
      end
      oahq_pkg::OP_RB_RD: begin
        slot_re = 1'b1;
        slot_raddr = scan[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  assign scr_we = (op == oahq_pkg::OP_RB_MOVE) && (rd_tag == oahq_pkg::TAG_OCC);
  assign scr_re = (op == oahq_pkg::OP_FETCH_SCR);

  oahq_ram #(.WIDTH(MW), .DEPTH(oahq_pkg::SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  oahq_ram #(.WIDTH(KW+VW), .DEPTH(oahq_pkg::SLOTS)) u_scratch_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (copied[AW-1:0]),
    .wdata ({rd_key, rd_data}),
    .re    (scr_re),
    .raddr (nxt[AW-1:0]),
    .rdata (scr_rdata)
  );

  always_comb begin
    stat.req_type     = req_type;
    stat.div_done     = div_done;
    stat.tag_empty    = (rd_tag == oahq_pkg::TAG_EMPTY);
    stat.tag_occ      = (rd_tag == oahq_pkg::TAG_OCC);
    stat.key_match    = (rd_key == work_key);
    stat.cnt_ge_limit = (cnt >= probe_limit);
    stat.cnt_gt_size  = (cnt > cur_size);
    stat.shrink_due   = (cur_size > min_size) && (del >= SW'(5)) &&
                        (five_occ < (SW+3)'(cur_size));
    stat.next_lt_end  = (nxt < endp);
    stat.sp_zero      = (sp == '0);
    stat.sp_full      = (sp == '1);
    stat.size_big     = (cur_size >= SW'(oahq_pkg::SLOTS / 2));
    stat.dsq_gt_cand  = ({1'b0, dsq} > (SW+1)'(cand));
    stat.rem_zero     = (div_rem == '0);
    stat.cand_over    = (cand > SW'(oahq_pkg::SLOTS));
    stat.cand_le2     = (cand <= SW'(2));
    stat.scan_lt_size = (scan < cur_size);
    stat.clr_last     = (clr == '1);
    stat.out_free     = !out_valid || out_ready;
    stat.cfg_clear    = cfg_we && (cfg_index == oahq_pkg::CFG_INIT_SIZE);
  end

  always_ff @(posedge clk) begin
    case (op)
      oahq_pkg::OP_CLR_STEP: clr <= clr + AW'(1);
      oahq_pkg::OP_ACCEPT: begin
        req_type <= in_type;
        work_key <= in_key;
        work_data <= in_value;
        is_req <= 1'b1;
        nxt <= '0;
        endp <= '0;
        res_status <= oahq_pkg::RES_MISS;
        res_slot <= '0;
        res_probes <= '0;
        res_fv <= '0;
        dropped <= 1'b0;
        stored <= 1'b0;
      end
      oahq_pkg::OP_HOME_SET: begin
        pos <= home[AW-1:0];
        delta <= AW'(1);
        cnt <= SW'(1);
      end
      oahq_pkg::OP_PROBE_STEP: begin
        pos <= (pos_sum >= cur_size) ? AW'(pos_sum - cur_size) : pos_sum[AW-1:0];
        delta <= (delta_sum >= cur_size) ? AW'(delta_sum - cur_size) : delta_sum[AW-1:0];
        cnt <= cnt + SW'(1);
      end
      oahq_pkg::OP_LK_FOUND: begin
        res_slot <= pos;
        res_probes <= cnt;
        case (req_type)
          oahq_pkg::REQ_REMOVE: begin
            res_status <= oahq_pkg::RES_DONE;
            occ <= occ - SW'(1);
            if (del != '1) del <= del + SW'(1);
          end
          oahq_pkg::REQ_SEARCH: begin
            res_status <= oahq_pkg::RES_DONE;
            res_fv <= rd_data;
          end
          default: res_status <= oahq_pkg::RES_MISS;
        endcase
      end
      oahq_pkg::OP_LK_MISS: res_probes <= cnt;
      oahq_pkg::OP_PLACE_WRITE: begin
        occ <= occ + SW'(1);
        if (cnt > max_run) max_run <= cnt;
        if (is_req) begin
          stored <= 1'b1;
          stored_slot <= pos;
          stored_run <= cnt;
        end
      end
      oahq_pkg::OP_DROP: dropped <= 1'b1;
      oahq_pkg::OP_CAND_GROW: cand <= {cur_size[SW-2:0], 1'b1};
      oahq_pkg::OP_CAND_SHRINK: cand <= (half <= SW'(2)) ? SW'(2) : half - SW'(1);
      oahq_pkg::OP_CAND_INC: cand <= cand + SW'(1);
      oahq_pkg::OP_CAND_DEC: cand <= cand - SW'(1);
      oahq_pkg::OP_PR_INIT: dvs <= oahq_pkg::DIV_W'(2);
      oahq_pkg::OP_PR_NEXTD: dvs <= dvs + oahq_pkg::DIV_W'(1);
      oahq_pkg::OP_PUSH: begin
        stack[sp] <= '{key: work_key, data: work_data, nxt: nxt, endp: endp,
                       is_req: is_req};
        sp <= sp + oahq_pkg::SP_W'(1);
      end
      oahq_pkg::OP_POP: begin
        sp <= sp - oahq_pkg::SP_W'(1);
        work_key <= top_frame.key;
        work_data <= top_frame.data;
        nxt <= top_frame.nxt;
        endp <= top_frame.endp;
        is_req <= top_frame.is_req;
      end
      oahq_pkg::OP_RB_START: begin
        new_size <= (cand < min_size) ? min_size : cand;
        scan <= '0;
        copied <= '0;
      end
      oahq_pkg::OP_RB_MOVE: begin
        if (rd_tag == oahq_pkg::TAG_OCC) copied <= copied + SW'(1);
        scan <= scan + SW'(1);
      end
      oahq_pkg::OP_RB_END: begin
        cur_size <= new_size;
        occ <= '0;
        del <= '0;
        max_run <= '0;
        endp <= copied;
        nxt <= '0;
      end
      oahq_pkg::OP_FETCH_SCR: begin
        nxt <= nxt + SW'(1);
        is_req <= 1'b0;
      end
      oahq_pkg::OP_LOAD_SCR: begin
        work_key <= scr_rdata[KW+VW-1 -: KW];
        work_data <= scr_rdata[VW-1:0];
      end
      oahq_pkg::OP_FIN_INS: begin
        res_slot <= stored ? stored_slot : res_slot;
        res_probes <= stored ? stored_run : '0;
        res_status <= (stored && !dropped) ? oahq_pkg::RES_DONE : oahq_pkg::RES_FULL;
      end
      oahq_pkg::OP_FIN_RM: begin
        res_status <= dropped ? oahq_pkg::RES_FULL : oahq_pkg::RES_DONE;
      end
      oahq_pkg::OP_OUT: begin
        out_status <= res_status;
        out_slot <= res_slot;
        out_probes <= res_probes;
        out_found_value <= res_fv;
        out_table_size <= cur_size;
        out_entry_count <= occ;
        out_longest_probe <= max_run;
      end
      default: begin
      end
    endcase

    if (op == oahq_pkg::OP_ACCEPT) begin
      sp <= '0;
    end

    // configuration writes win over any datapath command in the same cycle; reset wins over both
    if (cfg_we) begin
      if (cfg_index == oahq_pkg::CFG_INIT_SIZE) begin
        init_size <= cfg_data[AW-1:0];
        cur_size <= cfg_min;
        occ <= '0;
        del <= '0;
        max_run <= '0;
        clr <= '0;
      end else begin
        probe_limit <= cfg_data;
      end
    end

    if (rst) begin
      init_size <= AW'(13);
      probe_limit <= SW'(8);
      cur_size <= SW'(13);
      occ <= '0;
      del <= '0;
      max_run <= '0;
      clr <= '0;
      sp <= '0;
      out_valid <= 1'b0;
    end else if (op == oahq_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/open_address_hash_table_quadratic.sv
// Hash table with open addressing and quadratic probing over 4096 slots.
// One request is handled at a time. After reset, and after every write of
// initial_size while no request is in progress, a clearing pass empties the
// slot memory with the input held off. A request finds its home slot
// through a bit-serial remainder (one bit a cycle) and then examines slots
// one at a time (registered slot-memory read, then compare). A grow or
// shrink adds a prime search through the same remainder unit, one trial
// divisor at a time, a rebuild scan of the old slots, and the reinsertion
// of every entry at the cost of an insert each. A finished result waits in
// the output register; the next request may be taken meanwhile.
// Depends on oahq_pkg, oahq_ctrl, oahq_dp, oahq_ram and oahq_div.
module open_address_hash_table_quadratic (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key[31:0], value[63:32]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // slot[11:0], probes[24:12], found_value[56:25],
                                 // table_size[69:57], entry_count[82:70],
                                 // longest_probe[95:83]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  oahq_pkg::dp_op_t   op;
  oahq_pkg::dp_stat_t stat;
  logic                          ready;
  logic [oahq_pkg::ADDR_W-1:0]   slot;
  logic [oahq_pkg::CNT_W-1:0]    probes, table_size, entry_count, longest_probe;
  logic [oahq_pkg::VAL_W-1:0]    found_value;

  assign s_tready = ready;

  oahq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_type  (s_tuser),
    .stat     (stat),
    .op       (op),
    .ready    (ready)
  );

  oahq_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .op                (op),
    .stat              (stat),
    .in_type           (s_tuser),
    .in_key            (s_tdata[31:0]),
    .in_value          (s_tdata[63:32]),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (m_tready),
    .out_valid         (m_tvalid),
    .out_status        (m_tuser),
    .out_slot          (slot),
    .out_probes        (probes),
    .out_found_value   (found_value),
    .out_table_size    (table_size),
    .out_entry_count   (entry_count),
    .out_longest_probe (longest_probe)
  );

  assign m_tdata = {longest_probe, entry_count, table_size, found_value, probes, slot};

endmodule
